### hw/rtl/bis_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bilinear image scaler
package bis_pkg;
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned PIXEL_W = 3 * COLOUR_W;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_STEP_HORIZ    = 2'd2,
    CFG_STEP_VERT     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } command_t;

  typedef struct packed {
    logic                 command;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic [COLOUR_W-1:0]  red_in;
    logic [COLOUR_W-1:0]  green_in;
    logic [COLOUR_W-1:0]  blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red_out;
    logic [COLOUR_W-1:0] green_out;
    logic [COLOUR_W-1:0] blue_out;
    logic                clamped;
  } out_beat_t;
endpackage

### hw/rtl/bis_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat
interface bis_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/bis_blend.sv
`timescale 1ns / 1ps
// Pipelined per-colour blend of two neighbour pairs
module bis_blend #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bis_pkg::PIXEL_W-1:0]   p1,
  input  logic [bis_pkg::PIXEL_W-1:0]   p2,
  input  logic [bis_pkg::PIXEL_W-1:0]   p3,
  input  logic [bis_pkg::PIXEL_W-1:0]   p4,
  input  logic [FRACTION_BITS:0]        wu,
  input  logic [FRACTION_BITS:0]        wv,
  output logic [bis_pkg::PIXEL_W-1:0]   pix
);
  import bis_pkg::*;
  localparam int unsigned S1W = COLOUR_W + FRACTION_BITS + 1;
  localparam int unsigned S2W = S1W + FRACTION_BITS + 1;
  localparam logic [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

  logic [S1W-1:0] f1_r [3];
  logic [S1W-1:0] f2_r [3];
  logic [FRACTION_BITS:0] wv_r;
  logic [S2W-1:0] r_nxt [3];
  logic [FRACTION_BITS:0] iu, iv;

  assign iu = (FRACTION_BITS+1)'(ONE - {1'b0, wu});
  assign iv = (FRACTION_BITS+1)'(ONE - {1'b0, wv_r});

  always_ff @(posedge clk) begin
    if (en) begin
      wv_r <= wv;
      for (int c = 0; c < 3; c++) begin
        f1_r[c] <= S1W'(p1[c*COLOUR_W +: COLOUR_W] * iu)
                 + S1W'(p2[c*COLOUR_W +: COLOUR_W] * wu);
        f2_r[c] <= S1W'(p3[c*COLOUR_W +: COLOUR_W] * iu)
                 + S1W'(p4[c*COLOUR_W +: COLOUR_W] * wu);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r_nxt[c] = S2W'(f1_r[c] * iv) + S2W'(f2_r[c] * wv_r);
      pix[c*COLOUR_W +: COLOUR_W] = r_nxt[c][2*FRACTION_BITS +: COLOUR_W];
    end
  end
endmodule

### hw/rtl/bilinear_image_scaler.sv
`timescale 1ns / 1ps
// Top level of the bilinear image scaler
//  channel | dir | payload                              | accepted when
//  in_     | in  | command, column, row, red/green/blue | in_s.valid & in_s.ready
//  out_    | out | red/green/blue_out, clamped          | out_s.valid & out_s.ready
//  cfg_    | in  | cfg_index, cfg_data                  | cfg_we
// A request takes two dual-port reads of the frame store, so requests are never
// taken back to back; a load waits when it meets a request's first read. A result
// passes stage 0, stage 1, both reads, the blend and the output register.
// Reset clears control and presets the configuration; frame store is not cleared.
// A full output stage stalls the pipe and drops in_s.ready.
module bilinear_image_scaler #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bis_stream_if.sink                    in_s,
  bis_stream_if.source                  out_s,
  input  logic                          cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;
  localparam int unsigned XW = $clog2(MAX_COLUMNS);
  localparam int unsigned YW = $clog2(MAX_ROWS);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned PW = COORD_W + STEP_W;
  localparam int unsigned IW = PW - FRACTION_BITS;
  localparam int unsigned LW = 13;
  localparam int unsigned FW = FRACTION_BITS;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [STEP_W-1:0] step_h_r, step_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= SIZE_W'(256);
      height_r <= SIZE_W'(256);
      step_h_r <= STEP_W'(65536);
      step_v_r <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_WIDTH:  width_r <= cfg_data[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        CFG_STEP_HORIZ:    step_h_r <= cfg_data[STEP_W-1:0];
        CFG_STEP_VERT:     step_v_r <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] last_x, last_y;
  always_comb begin
    if (width_r == '0) last_x = '0;
    else if (LW'(width_r) > LW'(MAX_COLUMNS)) last_x = LW'(MAX_COLUMNS - 1);
    else last_x = LW'(width_r) - LW'(1);
    if (height_r == '0) last_y = '0;
    else if (LW'(height_r) > LW'(MAX_ROWS)) last_y = LW'(MAX_ROWS - 1);
    else last_y = LW'(height_r) - LW'(1);
  end

  // pipeline advance: stalls when an output beat waits and final stage is loaded
  logic adv;
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic busy_r, phase_r;
  logic out_v_r;
  out_beat_t out_r;
  assign adv = !out_v_r || out_s.ready || !s4_v_r;

  in_beat_t ib;
  assign ib = in_s.payload;
  logic take, is_load, load_ok;
  // hold a load while a request still has its second row to read
  assign in_s.ready = adv && !busy_r && !(is_load && s1_v_r && !phase_r);
  assign take = in_s.valid && in_s.ready;
  assign is_load = ib.command == CMD_LOAD;
  assign load_ok = (32'(ib.column) < MAX_COLUMNS) && (32'(ib.row) < MAX_ROWS);

  // stage 0: multiply
  logic [PW-1:0] pos_x_r, pos_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      busy_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= take && !is_load;
      busy_r <= take && !is_load;
    end
    if (adv && take) begin
      pos_x_r <= PW'(ib.column * step_h_r);
      pos_y_r <= PW'(ib.row * step_v_r);
    end
  end

  // stage 1: saturate and form addresses
  logic [IW-1:0] ix, iy;
  logic sat_x, sat_y;
  logic [XW-1:0] x1_r;
  logic [YW-1:0] y1_r;
  logic [FW:0] u_r, v_r;
  logic lc_r, lr_r, sat_r;
  assign ix = pos_x_r[PW-1:FW];
  assign iy = pos_y_r[PW-1:FW];
  assign sat_x = ix > IW'(last_x);
  assign sat_y = iy > IW'(last_y);
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= s0_v_r;
    if (adv) begin
      x1_r <= sat_x ? XW'(last_x) : XW'(ix);
      y1_r <= sat_y ? YW'(last_y) : YW'(iy);
      lc_r <= sat_x || (IW'(last_x) == ix);
      lr_r <= sat_y || (IW'(last_y) == iy);
      u_r <= {1'b0, sat_x ? FW'(0) : pos_x_r[FW-1:0]};
      v_r <= {1'b0, sat_y ? FW'(0) : pos_y_r[FW-1:0]};
      sat_r <= sat_x || sat_y;
    end
  end

  // stages 2/3: two dual-port reads of the frame store
  logic [PIXEL_W-1:0] store [2**AW];
  logic [AW-1:0] ra_a, ra_b;
  logic [PIXEL_W-1:0] rd_a_r, rd_b_r;
  logic [XW-1:0] x2;
  logic [YW-1:0] y2;
  logic [XW-1:0] x2_r;
  logic [YW-1:0] y2_r;
  logic [XW-1:0] x1q_r;
  logic [YW-1:0] y1q_r;
  logic [FW:0] u2_r, v2_r;
  logic lc2_r, lr2_r, sat2_r;
  assign x2 = lc_r ? x1_r : x1_r + XW'(1);
  assign y2 = lr_r ? y1_r : y1_r + YW'(1);
  always_comb begin
    if (phase_r) begin
      ra_a = {y2_r, x1q_r};
      ra_b = {y2_r, x2_r};
    end else begin
      ra_a = {y1_r, x1_r};
      ra_b = {y1_r, x2};
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_load && load_ok) store[{YW'(ib.row), XW'(ib.column)}] <= ib[3*COLOUR_W-1:0];
    if (adv) begin
      rd_a_r <= store[ra_a];
      rd_b_r <= store[ra_b];
    end
  end

  logic [PIXEL_W-1:0] p1_r, p2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      phase_r <= s1_v_r && !phase_r;
      s2_v_r <= s1_v_r && !phase_r;
      s3_v_r <= s2_v_r;
    end
    if (adv && s1_v_r && !phase_r) begin
      x1q_r <= x1_r;
      x2_r <= x2;
      y2_r <= y2;
      u2_r <= u_r;
      v2_r <= v_r;
      lc2_r <= lc_r;
      lr2_r <= lr_r;
      sat2_r <= sat_r;
    end
    if (adv && s2_v_r) begin
      p1_r <= rd_a_r;
      p2_r <= rd_b_r;
    end
  end

  // stage 3 feeds blend: rd_a/rd_b now hold p3/p4
  logic [FW:0] wu, wv;
  logic [PIXEL_W-1:0] blend_pix;
  logic sat4_r;
  assign wu = lc2_r ? '0 : u2_r;
  assign wv = lr2_r ? '0 : v2_r;
  bis_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
    .clk(clk), .en(adv && s3_v_r),
    .p1(p1_r), .p2(p2_r), .p3(rd_a_r), .p4(rd_b_r),
    .wu(wu), .wv(wv), .pix(blend_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv && s3_v_r) sat4_r <= sat2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (!out_v_r || out_s.ready) out_v_r <= s4_v_r;
    if ((!out_v_r || out_s.ready) && s4_v_r) begin
      out_r.red_out <= blend_pix[23:16];
      out_r.green_out <= blend_pix[15:8];
      out_r.blue_out <= blend_pix[7:0];
      out_r.clamped <= sat4_r;
    end
  end
  assign out_s.valid = out_v_r;
  assign out_s.payload = out_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_s.ready) else $error("request not given its second cycle");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> phase_r) else $error("read phase out of step");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_s.ready |=> out_v_r) else $error("beat dropped");
`endif
endmodule

### tb/tb_bilinear_image_scaler.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bilinear image scaler: frame loads, scaled requests, backpressure
module tb_bilinear_image_scaler;
  import bis_pkg::*;

  localparam int unsigned STORE_COLS = 256;
  localparam int unsigned STORE_ROWS = 256;
  localparam int unsigned FRAC = 16;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bis_stream_if #(.payload_t(in_beat_t)) in_ch ();
  bis_stream_if #(.payload_t(out_beat_t)) out_ch ();

  bilinear_image_scaler dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [PIXEL_W-1:0] frame_copy [STORE_COLS*STORE_ROWS];
  bit                 frame_written [STORE_COLS*STORE_ROWS];
  logic [SIZE_W-1:0]  src_width_reg, src_height_reg;
  logic [STEP_W-1:0]  step_h_reg, step_v_reg;
  out_beat_t          pixel_q [$];
  bit                 quiet;
  int                 hold_req;
  int                 mismatches, n_loads, n_requests, n_results, n_clamped, idle_cycles;

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] s, input int unsigned maxv);
    if (s == 0) return 1;
    if (s > maxv) return maxv;
    return s;
  endfunction

  function automatic int unsigned store_addr(input int unsigned x, input int unsigned y);
    return (y * STORE_COLS + x) % (STORE_COLS * STORE_ROWS);
  endfunction

  function automatic longint unsigned colour_at(input int unsigned x, input int unsigned y,
                                                input int ch);
    logic [PIXEL_W-1:0] px;
    px = frame_copy[store_addr(x, y)];
    return px[23-8*ch -: 8];
  endfunction

  // interpolate one output pixel; returns 0 where an unwritten entry would be read
  function automatic bit scale_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                                     output out_beat_t res);
    longint unsigned pos, u, v, c1, c2, c3, c4, f1, f2, acc;
    longint unsigned span;
    int unsigned w, h, x1, y1;
    bit sat, lc, lr;
    span = 64'd1 << FRAC;
    w = eff_size(src_width_reg, STORE_COLS);
    h = eff_size(src_height_reg, STORE_ROWS);
    sat = 1'b0;
    pos = longint'(c) * longint'(step_h_reg);
    u = pos & (span - 1);
    if ((pos >> FRAC) > w - 1) begin
      x1 = w - 1; u = 0; sat = 1'b1;
    end else x1 = 32'(pos >> FRAC);
    pos = longint'(r) * longint'(step_v_reg);
    v = pos & (span - 1);
    if ((pos >> FRAC) > h - 1) begin
      y1 = h - 1; v = 0; sat = 1'b1;
    end else y1 = 32'(pos >> FRAC);
    lc = (x1 >= w - 1);
    lr = (y1 >= h - 1);
    if (!frame_written[store_addr(x1, y1)]) return 0;
    if (!lc && !frame_written[store_addr(x1 + 1, y1)]) return 0;
    if (!lr && !frame_written[store_addr(x1, y1 + 1)]) return 0;
    if (!lc && !lr && !frame_written[store_addr(x1 + 1, y1 + 1)]) return 0;
    for (int ch = 0; ch < 3; ch++) begin
      c1 = colour_at(x1, y1, ch);
      if (lc && lr) acc = c1;
      else if (lc) begin
        c3 = colour_at(x1, y1 + 1, ch);
        acc = (c1 * (span - v) + c3 * v) >> FRAC;
      end else if (lr) begin
        c2 = colour_at(x1 + 1, y1, ch);
        acc = (c1 * (span - u) + c2 * u) >> FRAC;
      end else begin
        c2 = colour_at(x1 + 1, y1, ch);
        c3 = colour_at(x1, y1 + 1, ch);
        c4 = colour_at(x1 + 1, y1 + 1, ch);
        f1 = c1 * (span - u) + c2 * u;
        f2 = c3 * (span - u) + c4 * u;
        acc = (f1 * (span - v) + f2 * v) >> (2 * FRAC);
      end
      case (ch)
        0: res.red_out = acc[7:0];
        1: res.green_out = acc[7:0];
        default: res.blue_out = acc[7:0];
      endcase
    end
    res.clamped = sat;
    return 1;
  endfunction

  task automatic send_beat(input in_beat_t b);
    int gap;
    out_beat_t px;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (b.command == CMD_LOAD) begin
      n_loads++;
      if (b.column < STORE_COLS && b.row < STORE_ROWS) begin
        frame_copy[b.row * STORE_COLS + b.column] = {b.red_in, b.green_in, b.blue_in};
        frame_written[b.row * STORE_COLS + b.column] = 1'b1;
      end
    end else begin
      n_requests++;
      void'(scale_pixel(b.column, b.row, px));
      if (px.clamped) n_clamped++;
      pixel_q.push_back(px);
    end
  endtask

  task automatic load_pixel(input int unsigned c, input int unsigned r,
                            input logic [31:0] rgb);
    in_beat_t b;
    b.command = CMD_LOAD;
    b.column = COORD_W'(c);
    b.row = COORD_W'(r);
    {b.red_in, b.green_in, b.blue_in} = rgb[PIXEL_W-1:0];
    send_beat(b);
  endtask

  task automatic request_pixel(input int unsigned c, input int unsigned r);
    in_beat_t b;
    out_beat_t px;
    b.command = CMD_REQUEST;
    b.column = COORD_W'(c);
    b.row = COORD_W'(r);
    {b.red_in, b.green_in, b.blue_in} = PIXEL_W'($urandom);
    if (scale_pixel(b.column, b.row, px)) send_beat(b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h,
                              input int unsigned sh, input int unsigned sv);
    drain();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: begin
          cfg_index <= CFG_SOURCE_WIDTH;  cfg_data <= CFG_DATA_W'(w);  src_width_reg = SIZE_W'(w);
        end
        1: begin
          cfg_index <= CFG_SOURCE_HEIGHT; cfg_data <= CFG_DATA_W'(h); src_height_reg = SIZE_W'(h);
        end
        2: begin
          cfg_index <= CFG_STEP_HORIZ;    cfg_data <= CFG_DATA_W'(sh); step_h_reg = STEP_W'(sh);
        end
        default: begin
          cfg_index <= CFG_STEP_VERT;     cfg_data <= CFG_DATA_W'(sv); step_v_reg = STEP_W'(sv);
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // fill the origin block and the far edges so every kind of neighbour set is readable
  task automatic load_lattice();
    int unsigned w, h, xs [10], ys [10];
    w = eff_size(src_width_reg, STORE_COLS);
    h = eff_size(src_height_reg, STORE_ROWS);
    for (int i = 0; i < 10; i++) begin
      xs[i] = (i < 8) ? i : w + i - 10;
      ys[i] = (i < 8) ? i : h + i - 10;
    end
    for (int j = 0; j < 10; j++)
      for (int i = 0; i < 10; i++)
        if (xs[i] < w && ys[j] < h && (i < 8 || xs[i] >= 8) && (j < 8 || ys[j] >= 8))
          load_pixel(xs[i], ys[j], $urandom);
  endtask

  function automatic int unsigned near_limit(input logic [STEP_W-1:0] step);
    longint unsigned lim;
    if (step == 0) return 4095;
    lim = (longint'(10) << FRAC) / step + 1;
    return (lim > 4095) ? 4095 : 32'(lim);
  endfunction

  task automatic random_traffic(input int n);
    int unsigned c, r, pick;
    out_beat_t px;
    bit found;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) load_pixel($urandom_range(0, 4095), $urandom_range(256, 4095), $urandom);
      else if (pick < 15) load_pixel($urandom_range(256, 4095), $urandom_range(0, 4095), $urandom);
      else if (pick < 30) load_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      else begin
        found = 1'b0;
        for (int t = 0; t < 60 && !found; t++) begin
          c = ($urandom_range(0, 1) == 0) ? $urandom_range(0, near_limit(step_h_reg))
                                          : $urandom_range(0, 4095);
          r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, near_limit(step_v_reg))
                                          : $urandom_range(0, 4095);
          found = scale_pixel(COORD_W'(c), COORD_W'(r), px);
        end
        if (found) request_pixel(c, r);
        else load_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  task automatic test_directed();
    write_config(256, 256, 32'h010000, 32'h010000);
    load_pixel(0, 0, 24'hFFFFFF);
    load_pixel(1, 0, 24'h000000);
    load_pixel(0, 1, 24'h80FF01);
    load_pixel(1, 1, 24'h7F00FE);
    load_pixel(255, 255, 24'hA55AC3);
    load_pixel(254, 255, 24'h123456);
    load_pixel(255, 254, 24'hFEDCBA);
    load_pixel(4095, 4095, 24'hFFFFFF);
    load_pixel(255, 4095, 24'h000000);
    request_pixel(0, 0);
    request_pixel(255, 255);
    request_pixel(254, 255);
    request_pixel(255, 254);
    request_pixel(4095, 4095);
    request_pixel(4095, 255);
    write_config(256, 256, 32'h008000, 32'h00C000);
    request_pixel(1, 1);
    request_pixel(0, 1);
    write_config(256, 256, 32'h000001, 32'h000001);
    request_pixel(4095, 4095);
    write_config(256, 256, 32'h000000, 32'h000000);
    request_pixel(4095, 2730);
    write_config(1, 1, 32'hFFFFFF, 32'hFFFFFF);
    request_pixel(1, 0);
    request_pixel(0, 0);
  endtask

  task automatic test_scaling_phases();
    int unsigned ws [8] = '{256, 8, 1, 0, 511, 200, 13, 256};
    int unsigned hs [8] = '{256, 8, 1, 0, 300, 37, 256, 5};
    int unsigned shs [8] = '{32'h010000, 32'h008000, 32'h00C000, 32'h123456,
                             32'h010000, 32'h018000, 32'hFFFFFF, 32'h000000};
    int unsigned svs [8] = '{32'h010000, 32'h008000, 32'h000001, 32'h002000,
                             32'h00E000, 32'h023456, 32'h000001, 32'h010000};
    for (int p = 0; p < 8; p++) begin
      write_config(ws[p], hs[p], shs[p], svs[p]);
      quiet = ($urandom_range(0, 3) == 0);
      load_lattice();
      random_traffic(90);
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_config(16, 16, 32'h00A000, 32'h00B000);
    load_lattice();
    drain();
    quiet = 1'b1;
    hold_req = 120;
    @(posedge clk);
    random_traffic(40);
    quiet = 1'b0;
    drain();
    random_traffic(30);
  endtask

  always begin
    int stall;
    wait (rst_n === 1'b1);
    stall = 0;
    if (hold_req > 0) begin
      stall = hold_req;
      hold_req = 0;
    end else if (!quiet) stall = $urandom_range(0, 13);
    if (stall > 0) begin
      out_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ch.ready <= 1'b1;
    do @(posedge clk); while (!out_ch.valid);
    n_results++;
    if (pixel_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result beat with nothing expected: %p", out_ch.payload);
    end else if (out_ch.payload !== pixel_q[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: expected %p, got %p", pixel_q[0], out_ch.payload);
      void'(pixel_q.pop_front());
    end else void'(pixel_q.pop_front());
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    out_ch.ready <= 1'b0;
    src_width_reg = 256;
    src_height_reg = 256;
    step_h_reg = 24'h010000;
    step_v_reg = 24'h010000;
    quiet = 1'b0;
    hold_req = 0;
    mismatches = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_scaling_phases();
    test_backpressure();
    drain();
    $display("Covered %0d loads and %0d requests (%0d clamped), %0d result beats checked.",
             n_loads, n_requests, n_clamped, n_results);
    $display("Sizes 0..511, steps 0..max, edge, corner and saturation paths, long output stall.");
    if (mismatches == 0 && pixel_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### bilinear_image_scaler.f
hw/rtl/bis_pkg.sv
hw/rtl/bis_stream_if.sv
hw/rtl/bis_blend.sv
hw/rtl/bilinear_image_scaler.sv
tb/tb_bilinear_image_scaler.sv
